// ===== rtl/ple_pkg.sv =====
package ple_pkg;

    localparam int PLE_MAX_RESULTS = 32;

    localparam logic [2:0] REQ_APPEND = 3'd0;
    localparam logic [2:0] REQ_INSERT = 3'd1;
    localparam logic [2:0] REQ_REMOVE = 3'd2;
    localparam logic [2:0] REQ_FIND   = 3'd3;
    localparam logic [2:0] REQ_DUMP   = 3'd4;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_BAD_POS  = 2'd1;
    localparam logic [1:0] STS_FULL     = 2'd2;
    localparam logic [1:0] STS_NOT_FND  = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [5:0]         position;
        logic signed [31:0] value;
    } ple_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         index;
        logic signed [31:0] data;
        logic [5:0]         count;
        logic               last;
    } ple_result_t;

    // controller -> datapath
    typedef struct packed {
        logic exec;
        logic step;
        logic fin;
    } ple_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_req;
        logic is_find;
        logic emit_beat;
        logic scan_last;
        logic slot_free;
    } ple_stat_t;

endpackage

// ===== rtl/ple_ctrl.sv =====
module ple_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ple_pkg::ple_stat_t stat,
    output ple_pkg::ple_cmd_t  cmd
);
    import ple_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   step_ok;

    assign s_ready = (state_reg == ST_IDLE) && stat.slot_free;
    assign step_ok = !stat.emit_beat || stat.slot_free;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.exec = 1'b1;
                    if (stat.scan_req) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (step_ok) begin
                    cmd.step = 1'b1;
                    if (stat.scan_last) begin
                        state_next = stat.is_find ? ST_FIN : ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                if (stat.slot_free) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_scan_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && stat.scan_req) |=> (state_reg == ST_SCAN))
        else $error("scan request did not enter scan");
    a_fin_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin |-> (state_reg == ST_FIN && stat.slot_free))
        else $error("find result issued without free slot");
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.exec, cmd.step, cmd.fin}) <= 1)
        else $error("more than one datapath command");
`endif

endmodule

// ===== rtl/ple_datapath.sv =====
module ple_datapath #(
    parameter int CAPACITY = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ple_pkg::ple_req_t    s_data,
    input  ple_pkg::ple_cmd_t    cmd,
    output ple_pkg::ple_stat_t   stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ple_pkg::ple_result_t m_data
);
    import ple_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 6) ? CW : 6;

    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      step_reg, step_next;
    logic               found_reg, found_next;
    logic [4:0]         idx_reg, idx_next;
    logic               find_reg, find_next;
    logic signed [31:0] val_reg, val_next;
    logic               m_valid_reg, m_valid_next;
    ple_result_t        res_reg, res_next;

    logic signed [31:0] cell_reg  [CAPACITY];
    logic signed [31:0] cell_next [CAPACITY];
    logic signed [31:0] left_nb   [CAPACITY];
    logic signed [31:0] right_nb  [CAPACITY];

    logic [PW-1:0] n_ext, pos_ext, ins_pos, last_idx, dump_last, step_ext;
    logic          full, do_ins, do_rem, load;
    logic [1:0]    exec_status;

    assign n_ext     = PW'(count_reg);
    assign pos_ext   = PW'(s_data.position);
    assign step_ext  = PW'(step_reg);
    assign full      = (count_reg == CW'(CAPACITY));
    assign last_idx  = n_ext - PW'(1);
    assign dump_last = (n_ext > PW'(PLE_MAX_RESULTS)) ? PW'(PLE_MAX_RESULTS - 1) : last_idx;

    assign stat.slot_free = !m_valid_reg || m_ready;
    assign stat.scan_req  = ((s_data.req_type == REQ_FIND) || (s_data.req_type == REQ_DUMP))
                            && (count_reg != '0);
    assign stat.is_find   = find_reg;
    assign stat.emit_beat = !find_reg && (step_ext < PW'(PLE_MAX_RESULTS));
    assign stat.scan_last = (step_ext == last_idx);

    // request decode at intake
    always_comb begin
        do_ins      = 1'b0;
        do_rem      = 1'b0;
        ins_pos     = pos_ext;
        exec_status = STS_OK;
        case (s_data.req_type)
            REQ_APPEND: begin
                ins_pos = n_ext;
                if (full) begin
                    exec_status = STS_FULL;
                end else begin
                    do_ins = cmd.exec;
                end
            end
            REQ_INSERT: begin
                if (pos_ext > n_ext) begin
                    exec_status = STS_BAD_POS;
                end else if (full) begin
                    exec_status = STS_FULL;
                end else begin
                    do_ins = cmd.exec;
                end
            end
            REQ_REMOVE: begin
                if (pos_ext >= n_ext) begin
                    exec_status = STS_BAD_POS;
                end else begin
                    do_rem = cmd.exec;
                end
            end
            REQ_FIND: begin
                exec_status = STS_NOT_FND;
            end
            default: begin
                exec_status = STS_OK;
            end
        endcase
    end

    // cell row: shift for insert/remove, rotate the first count cells for scans
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            localparam logic [PW-1:0] IDX = PW'(g);
            if (g > 0) begin : g_left
                assign left_nb[g] = cell_reg[g-1];
            end else begin : g_left0
                assign left_nb[g] = cell_reg[g];
            end
            if (g < CAPACITY - 1) begin : g_right
                assign right_nb[g] = cell_reg[g+1];
            end else begin : g_right_end
                assign right_nb[g] = cell_reg[g];
            end

            always_comb begin
                cell_next[g] = cell_reg[g];
                if (do_ins) begin
                    if (IDX == ins_pos) begin
                        cell_next[g] = s_data.value;
                    end else if (IDX > ins_pos) begin
                        cell_next[g] = left_nb[g];
                    end
                end else if (do_rem) begin
                    if (IDX >= pos_ext) begin
                        cell_next[g] = right_nb[g];
                    end
                end else if (cmd.step) begin
                    if (IDX == last_idx) begin
                        cell_next[g] = cell_reg[0];
                    end else if (IDX < last_idx) begin
                        cell_next[g] = right_nb[g];
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        step_next  = step_reg;
        found_next = found_reg;
        idx_next   = idx_reg;
        find_next  = find_reg;
        val_next   = val_reg;
        load       = 1'b0;
        res_next   = res_reg;

        if (do_ins) begin
            count_next = count_reg + CW'(1);
        end else if (do_rem) begin
            count_next = count_reg - CW'(1);
        end

        if (cmd.exec) begin
            step_next  = '0;
            found_next = 1'b0;
            idx_next   = '0;
            find_next  = (s_data.req_type == REQ_FIND);
            val_next   = s_data.value;
            if (!stat.scan_req) begin
                load            = 1'b1;
                res_next.status = exec_status;
                res_next.index  = '0;
                res_next.data   = '0;
                res_next.count  = 6'(count_next);
                res_next.last   = 1'b1;
            end
        end else if (cmd.step) begin
            step_next = step_reg + CW'(1);
            if (find_reg && !found_reg && (cell_reg[0] == val_reg)) begin
                found_next = 1'b1;
                idx_next   = 5'(step_reg);
            end
            if (stat.emit_beat) begin
                load            = 1'b1;
                res_next.status = STS_OK;
                res_next.index  = '0;
                res_next.data   = cell_reg[0];
                res_next.count  = 6'(count_reg);
                res_next.last   = (step_ext == dump_last);
            end
        end else if (cmd.fin) begin
            load            = 1'b1;
            res_next.status = found_reg ? STS_OK : STS_NOT_FND;
            res_next.index  = found_reg ? idx_reg : 5'd0;
            res_next.data   = '0;
            res_next.count  = 6'(count_reg);
            res_next.last   = 1'b1;
        end

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            find_reg    <= 1'b0;
            found_reg   <= 1'b0;
            step_reg    <= '0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            find_reg    <= find_next;
            found_reg   <= found_next;
            step_reg    <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        val_reg  <= val_next;
        res_reg  <= res_next;
        cell_reg <= cell_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = res_reg;

`ifndef NO_ASSERTIONS
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> stat.slot_free)
        else $error("result register overwritten before taken");
    a_scan_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |=> $stable(count_reg))
        else $error("entry count changed during scan");
`endif

endmodule

// ===== rtl/positional_list_engine_core.sv =====
// Channel  Ports                      Beat contents
// -------  -------------------------  ---------------------------------------
// request  s_valid, s_ready, s_data   req_type, position, value
// result   m_valid, m_ready, m_data   status, index, data, count, last
//
// Append, insert, remove and unknown requests: accepted and answered at the same
// edge through the registered result slot, one request per cycle while the slot is free.
// Find: the entry row rotates once through cell 0 for the compare.
// Find or dump on an empty list is answered at intake like an edit request.
// Dump: one beat per cycle from the rotating row, paced by m_ready; intake waits.
// aresetn is synchronous, active low; it empties the list but does not clear cells.
// A stalled result slot holds back intake and dump beats.
module positional_list_engine_core #(
    parameter int CAPACITY = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ple_pkg::ple_req_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ple_pkg::ple_result_t m_data
);
    import ple_pkg::*;

    ple_cmd_t  cmd;
    ple_stat_t stat;

    ple_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ple_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
